[rtl/core/ipfwd_pkg.sv]
`timescale 1ns / 1ps
// Types, codes and sizes shared by the IPv4 forwarding decision block.
// No dependencies.
package ipfwd_pkg;

  localparam int RT_ENTRIES = 16;
  localparam int RT_IDX_W   = $clog2(RT_ENTRIES);
  localparam int RT_L1      = RT_ENTRIES / 2;   // candidates after the lookup stage
  localparam int RT_L2      = RT_ENTRIES / 8;   // candidates after the reduce stage
  localparam int PORT_COUNT = 4;
  localparam int CFG_REGS   = 4;

  // Verdict codes
  localparam logic [3:0] VERD_DROP          = 4'd0;
  localparam logic [3:0] VERD_ARP_REPLY     = 4'd1;
  localparam logic [3:0] VERD_ARP_LEARN     = 4'd2;
  localparam logic [3:0] VERD_ECHO_REPLY    = 4'd3;
  localparam logic [3:0] VERD_PORT_UNREACH  = 4'd4;
  localparam logic [3:0] VERD_FORWARD       = 4'd5;
  localparam logic [3:0] VERD_TIME_EXCEEDED = 4'd6;
  localparam logic [3:0] VERD_NET_UNREACH   = 4'd7;
  localparam logic [3:0] VERD_ROUTE_WRITTEN = 4'd8;

  localparam logic       ACT_ROUTE_WRITE = 1'b0;
  localparam logic [1:0] KIND_ARP        = 2'd1;
  localparam logic [1:0] KIND_IPV4       = 2'd2;
  localparam logic [1:0] ARP_OPC_REQ     = 2'd1;
  localparam logic [1:0] ARP_OPC_RPL     = 2'd2;
  localparam logic [7:0] PROTO_ICMP      = 8'd1;
  localparam logic [7:0] PROTO_TCP       = 8'd6;
  localparam logic [7:0] PROTO_UDP       = 8'd17;
  localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;
  localparam logic [7:0] TTL_ECHO        = 8'd64;
  localparam logic [7:0] TTL_ICMP_ERR    = 8'd255;

  typedef struct packed {
    logic        action;
    logic [1:0]  frame_kind;
    logic [1:0]  arp_opcode;
    logic        header_ok;
    logic [31:0] addr;
    logic [7:0]  ip_proto;
    logic [7:0]  icmp_kind;
    logic [7:0]  ttl;
    logic [1:0]  port;
    logic [3:0]  route_index;
    logic [31:0] route_mask;
    logic [31:0] route_gateway;
  } ipf_in_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [1:0]  out_port;
    logic [31:0] next_hop;
    logic [7:0]  new_ttl;
    logic [31:0] source_addr;
  } ipf_out_t;

  // One longest-prefix candidate as it moves down the reduce tree
  typedef struct packed {
    logic        hit;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [1:0]  egress;
  } rt_cand_t;

  // lo holds the lower slot numbers; it wins ties
  function automatic rt_cand_t rt_pick(rt_cand_t lo, rt_cand_t hi);
    if (hi.hit && (!lo.hit || hi.mask > lo.mask)) begin
      return hi;
    end
    return lo;
  endfunction

endpackage

[rtl/core/ipv4_forwarding_decision.sv]
`timescale 1ns / 1ps
// IPv4 forwarding decision: route table, header classification and
// pipelined longest-prefix match. Depends on ipfwd_pkg.
//
//  channel | ports                       | transfer
//  --------+-----------------------------+----------------------------------
//  input   | start, busy, in_data        | start & !busy at a rising edge
//  result  | out_strobe, out_data        | every cycle out_strobe is high
//  config  | cfg_valid, cfg_ready,       | cfg_valid & cfg_ready
//          | cfg_index, cfg_data         |
//
// One item enters per cycle while busy is low. Depth is set by the route
// compare stage, a two-level mask reduce stage and the final pick/verdict
// stage; each of them registers its result.
// Synchronous active-low reset clears route valid bits, interface
// addresses and pipeline valids; busy is high for the cycle after reset.
// The receiver cannot stall, so the pipeline never holds.
module ipv4_forwarding_decision (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ipfwd_pkg::ipf_in_t    in_data,
  output logic                  out_strobe,
  output ipfwd_pkg::ipf_out_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import ipfwd_pkg::*;

  logic        busy_r;
  logic [31:0] port_addr_r [CFG_REGS];

  logic        rt_valid_r  [RT_ENTRIES];
  logic [31:0] rt_prefix_r [RT_ENTRIES];
  logic [31:0] rt_mask_r   [RT_ENTRIES];
  logic [31:0] rt_gw_r     [RT_ENTRIES];
  logic [1:0]  rt_egress_r [RT_ENTRIES];

  logic        in_xfer;
  logic        rt_wr;
  logic [RT_IDX_W-1:0] rt_wr_idx;

  // stage 1
  logic        s1_valid_r, s1_lpm_r;
  ipf_out_t    s1_pre_r;
  logic [7:0]  s1_ttl_r;
  rt_cand_t    s1_cand_r [RT_L1];
  logic        s1_lpm_nxt;
  ipf_out_t    s1_pre_nxt;
  rt_cand_t    s1_cand_nxt [RT_L1];

  // stage 2
  logic        s2_valid_r, s2_lpm_r;
  ipf_out_t    s2_pre_r;
  logic [7:0]  s2_ttl_r;
  rt_cand_t    s2_cand_r [RT_L2];
  rt_cand_t    s2_cand_nxt [RT_L2];

  // output stage
  logic        out_strobe_r;
  ipf_out_t    out_data_r;
  ipf_out_t    out_data_nxt;

  assign busy       = busy_r;
  assign cfg_ready  = !busy_r;
  assign in_xfer    = start && !busy_r;
  assign rt_wr      = in_xfer && (in_data.action == ACT_ROUTE_WRITE)
                      && (int'(in_data.route_index) < RT_ENTRIES);
  assign rt_wr_idx  = in_data.route_index[RT_IDX_W-1:0];
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // ---- stage 1: classify header, compare all routes, first pair reduce ----
  always_comb begin
    logic [31:0] ing;
    logic        port_ok;
    logic        for_router;
    rt_cand_t    c_lo, c_hi;
    int          a, b;

    ing        = port_addr_r[in_data.port];
    port_ok    = int'(in_data.port) < PORT_COUNT;
    for_router = 1'b0;
    for (int p = 0; p < PORT_COUNT; p++) begin
      if (port_addr_r[p] == in_data.addr) begin
        for_router = 1'b1;
      end
    end

    s1_lpm_nxt = 1'b0;
    s1_pre_nxt = '0;
    s1_pre_nxt.verdict  = VERD_DROP;
    s1_pre_nxt.out_port = in_data.port;

    if (in_data.action == ACT_ROUTE_WRITE) begin
      s1_pre_nxt.verdict  = VERD_ROUTE_WRITTEN;
      s1_pre_nxt.out_port = '0;
    end else if (!port_ok) begin
      s1_pre_nxt.verdict = VERD_DROP;
    end else if (in_data.frame_kind == KIND_ARP) begin
      if (in_data.addr == ing && in_data.arp_opcode == ARP_OPC_REQ) begin
        s1_pre_nxt.verdict     = VERD_ARP_REPLY;
        s1_pre_nxt.source_addr = ing;
      end else if (in_data.addr == ing && in_data.arp_opcode == ARP_OPC_RPL) begin
        s1_pre_nxt.verdict = VERD_ARP_LEARN;
      end
    end else if (in_data.frame_kind != KIND_IPV4 || !in_data.header_ok) begin
      s1_pre_nxt.verdict = VERD_DROP;
    end else if (for_router) begin
      if (in_data.ip_proto == PROTO_ICMP && in_data.icmp_kind == ICMP_ECHO_REQ) begin
        s1_pre_nxt.verdict     = VERD_ECHO_REPLY;
        s1_pre_nxt.new_ttl     = TTL_ECHO;
        s1_pre_nxt.source_addr = in_data.addr;
      end else if (in_data.ip_proto == PROTO_TCP || in_data.ip_proto == PROTO_UDP) begin
        s1_pre_nxt.verdict     = VERD_PORT_UNREACH;
        s1_pre_nxt.new_ttl     = TTL_ICMP_ERR;
        s1_pre_nxt.source_addr = ing;
      end
    end else begin
      // route lookup; carry ingress address for the ICMP error cases
      s1_lpm_nxt             = 1'b1;
      s1_pre_nxt.source_addr = ing;
    end

    for (int j = 0; j < RT_L1; j++) begin
      a = 2 * j;
      b = 2 * j + 1;
      c_lo.hit    = rt_valid_r[a] && (((in_data.addr ^ rt_prefix_r[a]) & rt_mask_r[a]) == '0);
      c_lo.mask   = rt_mask_r[a];
      c_lo.gw     = rt_gw_r[a];
      c_lo.egress = rt_egress_r[a];
      c_hi.hit    = rt_valid_r[b] && (((in_data.addr ^ rt_prefix_r[b]) & rt_mask_r[b]) == '0);
      c_hi.mask   = rt_mask_r[b];
      c_hi.gw     = rt_gw_r[b];
      c_hi.egress = rt_egress_r[b];
      s1_cand_nxt[j] = rt_pick(c_lo, c_hi);
    end
  end

  // ---- stage 2: two reduce levels ----
  always_comb begin
    rt_cand_t lvl [RT_L1/2];
    for (int j = 0; j < RT_L1 / 2; j++) begin
      lvl[j] = rt_pick(s1_cand_r[2*j], s1_cand_r[2*j+1]);
    end
    for (int k = 0; k < RT_L2; k++) begin
      s2_cand_nxt[k] = rt_pick(lvl[2*k], lvl[2*k+1]);
    end
  end

  // ---- stage 3: last pick and route verdict ----
  always_comb begin
    rt_cand_t best;
    best         = rt_pick(s2_cand_r[0], s2_cand_r[1]);
    out_data_nxt = s2_pre_r;
    if (s2_lpm_r) begin
      out_data_nxt.next_hop = '0;
      if (!best.hit) begin
        out_data_nxt.verdict = VERD_NET_UNREACH;
        out_data_nxt.new_ttl = TTL_ICMP_ERR;
      end else if (s2_ttl_r[7:1] == '0) begin
        // arriving TTL of zero or one has expired
        out_data_nxt.verdict = VERD_TIME_EXCEEDED;
        out_data_nxt.new_ttl = TTL_ICMP_ERR;
      end else begin
        out_data_nxt.verdict     = VERD_FORWARD;
        out_data_nxt.out_port    = best.egress;
        out_data_nxt.next_hop    = best.gw;
        out_data_nxt.new_ttl     = s2_ttl_r - 8'd1;
        out_data_nxt.source_addr = '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int p = 0; p < CFG_REGS; p++) begin
        port_addr_r[p] <= '0;
      end
      for (int i = 0; i < RT_ENTRIES; i++) begin
        rt_valid_r[i] <= 1'b0;
      end
    end else begin
      busy_r       <= 1'b0;
      s1_valid_r   <= in_xfer;
      s2_valid_r   <= s1_valid_r;
      out_strobe_r <= s2_valid_r;
      if (cfg_valid && cfg_ready) begin
        port_addr_r[cfg_index] <= cfg_data;
      end
      if (rt_wr) begin
        rt_valid_r[rt_wr_idx] <= 1'b1;
      end
    end
  end

  // route payload and pipeline payload
  always_ff @(posedge clk) begin
    if (rt_wr) begin
      rt_prefix_r[rt_wr_idx] <= in_data.addr;
      rt_mask_r[rt_wr_idx]   <= in_data.route_mask;
      rt_gw_r[rt_wr_idx]     <= in_data.route_gateway;
      rt_egress_r[rt_wr_idx] <= in_data.port;
    end
    s1_lpm_r  <= s1_lpm_nxt;
    s1_pre_r  <= s1_pre_nxt;
    s1_ttl_r  <= in_data.ttl;
    s1_cand_r <= s1_cand_nxt;
    s2_lpm_r  <= s1_lpm_r;
    s2_pre_r  <= s1_pre_r;
    s2_ttl_r  <= s1_ttl_r;
    s2_cand_r <= s2_cand_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---- assertions ----
  a_strobe_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_xfer, 3))
    else $error("result without an accepted item");

  a_item_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_xfer, 3) && $past(rst_n, 2) && $past(rst_n, 1)) |-> out_strobe)
    else $error("accepted item lost");

  a_forward_ttl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.verdict == VERD_FORWARD) |->
      (out_data.new_ttl != '0 && out_data.source_addr == '0))
    else $error("forward with bad ttl or source");

  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.verdict == VERD_ROUTE_WRITTEN) |->
      (out_data.next_hop == '0 && out_data.new_ttl == '0
       && out_data.source_addr == '0 && out_data.out_port == '0))
    else $error("route write result not clean");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for ipv4_forwarding_decision: directed and random frames,
// route writes and interface address changes, checked against a behavioral model.
// Depends on ipfwd_pkg and the ipv4_forwarding_decision RTL.
module tb;
  import ipfwd_pkg::*;

  localparam int         CLK_HALF    = 4;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         TAIL_CYCLES = 8;
  localparam logic       ACT_FRAME   = 1'b1;
  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_RSVD   = 2'd3;
  localparam logic [1:0] ARP_OP_NONE = 2'd0;
  localparam logic [1:0] ARP_OP_RSVD = 2'd3;
  localparam logic [7:0] ICMP_ECHO_RPLY = 8'd0;

  localparam logic [1:0] REG_IF0_ADDR = 2'd0;
  localparam logic [1:0] REG_IF1_ADDR = 2'd1;
  localparam logic [1:0] REG_IF2_ADDR = 2'd2;
  localparam logic [1:0] REG_IF3_ADDR = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  ipf_in_t     in_data   = '0;
  logic        out_strobe;
  ipf_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  // model state
  logic [31:0] iface_addr [PORT_COUNT];
  logic        route_ok   [RT_ENTRIES];
  logic [31:0] route_pfx  [RT_ENTRIES];
  logic [31:0] route_msk  [RT_ENTRIES];
  logic [31:0] route_gw   [RT_ENTRIES];
  logic [1:0]  route_port [RT_ENTRIES];

  ipf_out_t pending_verdicts [$];
  int       fail_count  = 0;
  int       cycle_count = 0;
  int       idle_pct    = 0;

  ipv4_forwarding_decision u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ipv4_forwarding_decision verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] mask_of_len(int len);
    return (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - len);
  endfunction

  function automatic ipf_out_t make_verdict(logic [3:0] v, logic [1:0] p, logic [31:0] hop,
                                            logic [7:0] ttl, logic [31:0] src);
    ipf_out_t o;
    o.verdict     = v;
    o.out_port    = p;
    o.next_hop    = hop;
    o.new_ttl     = ttl;
    o.source_addr = src;
    return o;
  endfunction

  function automatic logic is_router_addr(logic [31:0] a);
    for (int p = 0; p < PORT_COUNT; p++) begin
      if (iface_addr[p] == a) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Expected verdict for one transfer; route writes update the table
  function automatic ipf_out_t decide_forwarding(ipf_in_t it);
    logic [31:0] ing;
    logic [31:0] best_m;
    int          best;
    best   = -1;
    best_m = '0;
    if (it.action == ACT_ROUTE_WRITE) begin
      route_ok[it.route_index]   = 1'b1;
      route_pfx[it.route_index]  = it.addr;
      route_msk[it.route_index]  = it.route_mask;
      route_gw[it.route_index]   = it.route_gateway;
      route_port[it.route_index] = it.port;
      return make_verdict(VERD_ROUTE_WRITTEN, '0, '0, '0, '0);
    end
    if (it.port >= PORT_COUNT) return make_verdict(VERD_DROP, it.port, '0, '0, '0);
    ing = iface_addr[it.port];
    if (it.frame_kind == KIND_ARP) begin
      if (it.arp_opcode == ARP_OPC_REQ && it.addr == ing)
        return make_verdict(VERD_ARP_REPLY, it.port, '0, '0, ing);
      if (it.arp_opcode == ARP_OPC_RPL && it.addr == ing)
        return make_verdict(VERD_ARP_LEARN, it.port, '0, '0, '0);
      return make_verdict(VERD_DROP, it.port, '0, '0, '0);
    end
    if (it.frame_kind != KIND_IPV4 || !it.header_ok)
      return make_verdict(VERD_DROP, it.port, '0, '0, '0);
    if (is_router_addr(it.addr)) begin
      if (it.ip_proto == PROTO_ICMP && it.icmp_kind == ICMP_ECHO_REQ)
        return make_verdict(VERD_ECHO_REPLY, it.port, '0, TTL_ECHO, it.addr);
      if (it.ip_proto == PROTO_TCP || it.ip_proto == PROTO_UDP)
        return make_verdict(VERD_PORT_UNREACH, it.port, '0, TTL_ICMP_ERR, ing);
      return make_verdict(VERD_DROP, it.port, '0, '0, '0);
    end
    // longest mask wins, lowest slot on a tie
    for (int i = 0; i < RT_ENTRIES; i++) begin
      if (route_ok[i] && ((it.addr & route_msk[i]) == (route_pfx[i] & route_msk[i])) &&
          (best < 0 || route_msk[i] > best_m)) begin
        best   = i;
        best_m = route_msk[i];
      end
    end
    if (best < 0) return make_verdict(VERD_NET_UNREACH, it.port, '0, TTL_ICMP_ERR, ing);
    if (it.ttl <= 8'd1) return make_verdict(VERD_TIME_EXCEEDED, it.port, '0, TTL_ICMP_ERR, ing);
    return make_verdict(VERD_FORWARD, route_port[best], route_gw[best], it.ttl - 8'd1, '0);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ipf_out_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no transfer pending: verdict 0x%0h", out_data.verdict);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 32'(want.verdict), 32'(out_data.verdict));
        check_field("out_port", 32'(want.out_port), 32'(out_data.out_port));
        check_field("next_hop", want.next_hop, out_data.next_hop);
        check_field("new_ttl", 32'(want.new_ttl), 32'(out_data.new_ttl));
        check_field("source_addr", want.source_addr, out_data.source_addr);
      end
    end
  end

  task automatic send_item(input ipf_in_t item);
    int gap;
    gap = 0;
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    pending_verdicts.push_back(decide_forwarding(item));
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    iface_addr[idx] = val;
  endtask

  // drains the pipeline first, then writes the interface addresses
  task automatic set_iface_addrs(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                                 logic [31:0] a3);
    wait_drained();
    write_reg(REG_IF0_ADDR, a0);
    write_reg(REG_IF1_ADDR, a1);
    write_reg(REG_IF2_ADDR, a2);
    write_reg(REG_IF3_ADDR, a3);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic ipf_in_t rand_item();
    ipf_in_t it;
    it = {$urandom(), $urandom(), $urandom(), $urandom(), 4'($urandom())};
    return it;
  endfunction

  function automatic ipf_in_t mk_frame(logic [1:0] kind, logic [1:0] p, logic [31:0] a);
    ipf_in_t it;
    it            = rand_item();
    it.action     = ACT_FRAME;
    it.frame_kind = kind;
    it.port       = p;
    it.addr       = a;
    it.header_ok  = 1'b1;
    return it;
  endfunction

  function automatic ipf_in_t mk_arp(logic [1:0] op, logic [1:0] p, logic [31:0] a);
    ipf_in_t it;
    it            = mk_frame(KIND_ARP, p, a);
    it.arp_opcode = op;
    return it;
  endfunction

  function automatic ipf_in_t mk_ip(logic [1:0] p, logic [31:0] a, logic [7:0] proto,
                                    logic [7:0] icmp, logic [7:0] ttl);
    ipf_in_t it;
    it           = mk_frame(KIND_IPV4, p, a);
    it.ip_proto  = proto;
    it.icmp_kind = icmp;
    it.ttl       = ttl;
    return it;
  endfunction

  function automatic ipf_in_t mk_route(logic [3:0] idx, logic [31:0] pfx, logic [31:0] msk,
                                       logic [31:0] gw, logic [1:0] p);
    ipf_in_t it;
    it               = rand_item();
    it.action        = ACT_ROUTE_WRITE;
    it.route_index   = idx;
    it.addr          = pfx;
    it.route_mask    = msk;
    it.route_gateway = gw;
    it.port          = p;
    return it;
  endfunction

  // destination inside a random table entry, or anywhere when that slot is empty
  function automatic logic [31:0] routed_addr();
    int          s;
    logic [31:0] host;
    s    = $urandom_range(RT_ENTRIES - 1);
    host = $urandom();
    if (!route_ok[s]) return host;
    return (route_pfx[s] & route_msk[s]) | (host & ~route_msk[s]);
  endfunction

  function automatic ipf_in_t gen_item();
    ipf_in_t it;
    int      r;
    it = rand_item();
    r  = $urandom_range(99);
    if (r < 8) begin
      it.action     = ACT_ROUTE_WRITE;
      if ($urandom_range(9) != 0) it.route_mask = mask_of_len($urandom_range(32));
      return it;
    end
    it.action = ACT_FRAME;
    r = $urandom_range(99);
    if (r < 15) begin
      it.frame_kind = $urandom_range(1) ? KIND_OTHER : KIND_RSVD;
    end else if (r < 35) begin
      it.frame_kind = KIND_ARP;
      if ($urandom_range(9) < 8)
        it.arp_opcode = $urandom_range(1) ? ARP_OPC_REQ : ARP_OPC_RPL;
      if ($urandom_range(9) < 7) it.addr = iface_addr[it.port];
    end else begin
      it.frame_kind = KIND_IPV4;
      it.header_ok  = ($urandom_range(9) != 0);
      r = $urandom_range(9);
      if (r < 3) it.addr = iface_addr[$urandom_range(PORT_COUNT - 1)];
      else if (r < 8) it.addr = routed_addr();
      r = $urandom_range(9);
      if (r < 4) it.ip_proto = PROTO_ICMP;
      else if (r < 6) it.ip_proto = PROTO_TCP;
      else if (r < 8) it.ip_proto = PROTO_UDP;
      if ($urandom_range(9) < 6) it.icmp_kind = ICMP_ECHO_REQ;
      if ($urandom_range(99) < 15) it.ttl = 8'($urandom_range(2));
    end
    return it;
  endfunction

  task automatic test_local_traffic();
    idle_pct = 0;
    set_iface_addrs(32'h0A00_0001, 32'hC0A8_0101, 32'h0000_0000, 32'hFFFF_FFFF);
    // empty table: nothing matches
    send_item(mk_ip(2'd0, 32'h0808_0808, PROTO_TCP, ICMP_ECHO_REQ, 8'd64));
    send_item(mk_arp(ARP_OPC_REQ, 2'd0, 32'h0A00_0001));
    send_item(mk_arp(ARP_OPC_RPL, 2'd1, 32'hC0A8_0101));
    send_item(mk_arp(ARP_OPC_REQ, 2'd0, 32'hC0A8_0101));
    send_item(mk_arp(ARP_OP_NONE, 2'd0, 32'h0A00_0001));
    send_item(mk_arp(ARP_OP_RSVD, 2'd3, 32'hFFFF_FFFF));
    send_item(mk_frame(KIND_OTHER, 2'd0, 32'h0A00_0001));
    send_item(mk_frame(KIND_RSVD, 2'd2, 32'h0000_0000));
    begin
      ipf_in_t bad;
      bad = mk_ip(2'd0, 32'h0A00_0001, PROTO_ICMP, ICMP_ECHO_REQ, 8'd64);
      bad.header_ok = 1'b0;
      send_item(bad);
    end
    send_item(mk_ip(2'd3, 32'hC0A8_0101, PROTO_ICMP, ICMP_ECHO_REQ, 8'd1));
    send_item(mk_ip(2'd0, 32'h0A00_0001, PROTO_ICMP, ICMP_ECHO_RPLY, 8'd64));
    send_item(mk_ip(2'd1, 32'hFFFF_FFFF, PROTO_TCP, 8'd255, 8'd0));
    send_item(mk_ip(2'd2, 32'h0000_0000, PROTO_UDP, 8'd0, 8'd255));
    send_item(mk_ip(2'd0, 32'h0A00_0001, 8'd255, ICMP_ECHO_REQ, 8'd64));
  endtask

  task automatic test_route_lookup();
    idle_pct = 0;
    send_item(mk_route(4'd15, 32'h0000_0000, mask_of_len(0), 32'hC0A8_01FE, 2'd3));
    send_item(mk_route(4'd0, 32'h0A00_0000, mask_of_len(8), 32'h0A00_00FE, 2'd1));
    send_item(mk_route(4'd1, 32'h0A01_0200, mask_of_len(24), 32'h0A01_0201, 2'd2));
    // same prefix and mask in a higher slot loses the tie
    send_item(mk_route(4'd2, 32'h0A01_0277, mask_of_len(24), 32'h0A01_0202, 2'd0));
    send_item(mk_route(4'd3, 32'h0A01_0203, mask_of_len(32), 32'hFFFF_FFFF, 2'd0));
    send_item(mk_ip(2'd0, 32'h0A01_0203, PROTO_TCP, 8'd0, 8'd255));
    send_item(mk_ip(2'd1, 32'h0A01_0209, PROTO_UDP, 8'd0, 8'd2));
    send_item(mk_ip(2'd2, 32'h0A09_0909, PROTO_ICMP, ICMP_ECHO_REQ, 8'd1));
    send_item(mk_ip(2'd3, 32'h0A09_0909, PROTO_ICMP, ICMP_ECHO_REQ, 8'd0));
    send_item(mk_ip(2'd0, 32'hAC10_0001, 8'd0, 8'd0, 8'd64));
    send_item(mk_ip(2'd1, 32'hFFFF_FFFE, PROTO_TCP, 8'd0, 8'd128));
  endtask

  task automatic test_random_traffic(int count, int idle);
    idle_pct = idle;
    repeat (count) send_item(gen_item());
  endtask

  initial begin
    logic [31:0] same;
    for (int i = 0; i < RT_ENTRIES; i++) route_ok[i] = 1'b0;
    for (int p = 0; p < PORT_COUNT; p++) iface_addr[p] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_local_traffic();
    test_route_lookup();

    set_iface_addrs($urandom(), $urandom(), $urandom(), $urandom());
    test_random_traffic(300, 0);
    set_iface_addrs('0, '0, '0, '0);
    test_random_traffic(300, 64);
    set_iface_addrs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_random_traffic(300, 15);
    same = $urandom();
    set_iface_addrs(same, same, same, same);
    test_random_traffic(300, 0);
    set_iface_addrs($urandom(), $urandom(), $urandom(), $urandom());
    test_random_traffic(300, 64);
    set_iface_addrs(routed_addr(), routed_addr(), $urandom(), 32'h0000_0000);
    test_random_traffic(300, 15);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ipv4_forwarding_decision verification clean");
    end else begin
      $display("ipv4_forwarding_decision verification failed");
    end
    $finish;
  end

endmodule
